/* hdl/acir_pkg.sv */
// Shared types and constants for the IR remote frame encoder.
// Used by acir_frame, acir_seq and the top level; depends on nothing.
package acir_pkg;

	localparam int FRAME_BITS   = 96;
	localparam int BIT_IDX_W    = 7;
	localparam int SYMBOL_COUNT = 196;
	localparam int SYM_IDX_W    = 8;
	localparam int CFG_INDEX_W  = 3;

	localparam logic [7:0] PREAMBLE_A = 8'hAC;
	localparam logic [7:0] PREAMBLE_B = 8'hF5;
	localparam logic [1:0] POST_BITS  = 2'b10;
	localparam logic [7:0] TEMP_OFFSET = 8'd4;
	localparam logic [7:0] TEMP_MIN   = 8'd16;
	localparam logic [7:0] TEMP_MAX   = 8'd30;
	localparam logic [2:0] FLAP_FULL  = 3'd7;
	localparam logic [2:0] FLAP_AUTO  = 3'd0;
	localparam int         CHECK_INIT = 2;
	// Constant part of the checksum: seed plus both preamble bytes
	localparam logic [7:0] CHECK_BASE =
		8'((CHECK_INIT + 32'hAC + 32'hF5) % 256);

	// Input actions
	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

	// Timing register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_HEADER_MARK  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SPACE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BIT_MARK     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ONE_SPACE    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ZERO_SPACE   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_GAP          = 3'd5;

	// Mode input codes
	localparam logic [2:0] MODE_AUTO = 3'd0;
	localparam logic [2:0] MODE_COOL = 3'd1;
	localparam logic [2:0] MODE_DRY  = 3'd2;
	localparam logic [2:0] MODE_HEAT = 3'd3;
	localparam logic [2:0] MODE_FAN  = 3'd4;

	// Mode codes as sent in the frame
	localparam logic [2:0] FCODE_AUTO = 3'd2;
	localparam logic [2:0] FCODE_COOL = 3'd0;
	localparam logic [2:0] FCODE_DRY  = 3'd1;
	localparam logic [2:0] FCODE_HEAT = 3'd4;
	localparam logic [2:0] FCODE_FAN  = 3'd3;

	typedef struct packed {
		logic       action;
		logic [2:0] ac_mode;
		logic [7:0] temperature;
		logic [1:0] fan_speed;
		logic       swing_on;
		logic       power_on;
	} cmd_t;

	typedef struct packed {
		logic        level;
		logic [15:0] duration;
		logic        last_symbol;
	} sym_t;

	typedef struct packed {
		logic [15:0] header_mark_us;
		logic [15:0] header_space_us;
		logic [15:0] bit_mark_us;
		logic [15:0] one_space_us;
		logic [15:0] zero_space_us;
		logic [15:0] gap_us;
	} timing_t;

	function automatic logic [2:0] mode_code(input logic [2:0] mode);
		logic [2:0] code;
		case (mode)
			MODE_COOL: code = FCODE_COOL;
			MODE_DRY:  code = FCODE_DRY;
			MODE_HEAT: code = FCODE_HEAT;
			MODE_FAN:  code = FCODE_FAN;
			default:   code = FCODE_AUTO;
		endcase
		return code;
	endfunction

endpackage

/* hdl/acir_frame.sv */
// Packs one command into the 96-bit frame, checksum included.
// Depends on acir_pkg.
module acir_frame (
	input  acir_pkg::cmd_t                    cmd,
	output logic [acir_pkg::FRAME_BITS-1:0]   frame
);

	logic [7:0] temp_clamped;
	logic [4:0] temp_field;
	logic [7:0] check;
	logic [acir_pkg::FRAME_BITS-1:0] body;

	// Clamp temperature and remove the offset
	always_comb begin
		if (cmd.temperature < acir_pkg::TEMP_MIN) begin
			temp_clamped = acir_pkg::TEMP_MIN;
		end else if (cmd.temperature > acir_pkg::TEMP_MAX) begin
			temp_clamped = acir_pkg::TEMP_MAX;
		end else begin
			temp_clamped = cmd.temperature;
		end
		temp_field = 5'(temp_clamped - acir_pkg::TEMP_OFFSET);
	end

	// Place the fields
	always_comb begin
		body          = '0;
		body[7:0]     = acir_pkg::PREAMBLE_A;
		body[15:8]    = acir_pkg::PREAMBLE_B;
		body[21:19]   = acir_pkg::mode_code(cmd.ac_mode);
		body[26:22]   = temp_field;
		body[28:27]   = cmd.fan_speed;
		body[36:34]   = cmd.swing_on ? acir_pkg::FLAP_FULL : acir_pkg::FLAP_AUTO;
		body[77]      = cmd.power_on;
		body[81:80]   = acir_pkg::POST_BITS;
	end

	// Checksum over bytes 0..9; only bytes 2, 3, 4 and 9 vary
	assign check = acir_pkg::CHECK_BASE + body[23:16] + body[31:24]
		+ body[39:32] + body[79:72];

	always_comb begin
		frame        = body;
		frame[89:82] = check;
	end

endmodule

/* hdl/acir_seq.sv */
// Symbol sequencer: holds the frame, the symbol index and the busy flag,
// and picks the duration of each symbol. Depends on acir_pkg and acir_frame.
module acir_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  acir_pkg::cmd_t      item,
	input  acir_pkg::timing_t   timing,
	output logic                res_valid,
	output acir_pkg::sym_t      res
);

	localparam logic [acir_pkg::SYM_IDX_W-1:0] IDX_LAST =
		acir_pkg::SYM_IDX_W'(acir_pkg::SYMBOL_COUNT - 1);
	localparam logic [acir_pkg::SYM_IDX_W-1:0] IDX_END_MARK =
		acir_pkg::SYM_IDX_W'(acir_pkg::SYMBOL_COUNT - 2);
	localparam logic [acir_pkg::SYM_IDX_W-1:0] IDX_HDR_MARK  = '0;
	localparam logic [acir_pkg::SYM_IDX_W-1:0] IDX_HDR_SPACE = acir_pkg::SYM_IDX_W'(1);

	logic [acir_pkg::FRAME_BITS-1:0] frame_new;
	logic [acir_pkg::FRAME_BITS-1:0] frame_q;
	logic [acir_pkg::SYM_IDX_W-1:0]  idx_q;
	logic                            busy_q;
	logic [acir_pkg::SYM_IDX_W-1:0]  idx_off;
	logic [acir_pkg::BIT_IDX_W-1:0]  bit_idx;
	logic                            is_load;

	acir_frame u_frame (
		.cmd   (item),
		.frame (frame_new)
	);

	assign is_load   = (item.action == acir_pkg::ACT_LOAD);
	assign res_valid = step && !is_load && busy_q;
	assign idx_off   = idx_q - acir_pkg::SYM_IDX_W'(2);
	assign bit_idx   = idx_off[acir_pkg::BIT_IDX_W:1];

	// Select the symbol for the current index
	always_comb begin
		res.level       = ~idx_q[0];
		res.last_symbol = 1'b0;
		if (idx_q == IDX_HDR_MARK) begin
			res.duration = timing.header_mark_us;
		end else if (idx_q == IDX_HDR_SPACE) begin
			res.duration = timing.header_space_us;
		end else if (idx_q == IDX_LAST) begin
			res.duration    = timing.gap_us;
			res.last_symbol = 1'b1;
		end else if (idx_q == IDX_END_MARK || !idx_q[0]) begin
			res.duration = timing.bit_mark_us;
		end else if (frame_q[bit_idx]) begin
			res.duration = timing.one_space_us;
		end else begin
			res.duration = timing.zero_space_us;
		end
	end

	// Frame store: written by a load only
	always_ff @(posedge clk) begin
		if (step && is_load) begin
			frame_q <= frame_new;
		end
	end

	// Restart on load, advance on each emitted symbol, drop busy after the gap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			busy_q <= 1'b0;
		end else if (step && is_load) begin
			idx_q  <= '0;
			busy_q <= 1'b1;
		end else if (res_valid) begin
			if (res.last_symbol) begin
				idx_q  <= '0;
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + acir_pkg::SYM_IDX_W'(1);
			end
		end
	end

	a_idle_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> idx_q == '0)
		else $error("index not at zero while idle");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_LAST)
		else $error("symbol index beyond end of frame");

	a_load_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_load |=> busy_q && idx_q == '0)
		else $error("load did not restart the frame");

	a_gap_ends: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last_symbol |=> !busy_q)
		else $error("still busy after the gap symbol");

endmodule

/* hdl/ac_remote_ir_frame_encoder_top.sv */
// Top level of the IR remote frame encoder: input register, timing
// registers, output register. Depends on acir_pkg and acir_seq.
//
// Usage:
//  cmd channel (cmd_valid, cmd_stall, cmd): a load transaction latches an
//   air-conditioner command and restarts the frame; an advance transaction
//   asks for the next mark or space. A load or an idle advance gives no
//   result.
//  sym channel (sym_valid, sym_stall, sym): one symbol per busy advance,
//   level, duration in microseconds, and last_symbol on the final gap.
//   A frame is 196 symbols.
//  cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data): six 16-bit
//   timing registers, always ready; indexes above five are ignored. Write
//   only while no transaction is in flight.
// An accepted advance is held in the input register, and its symbol is shown
//  from the output register. Throughput: one transaction per cycle while
//  sym_stall is low; the symbol select between the two registers is combinational.
// Reset: idle, no frame, timing registers at their defaults.
// When sym_stall is high with a symbol waiting, the input register fills
//  and then cmd_stall rises; every transaction, with or without a result,
//  waits there until the symbol is taken.
module ac_remote_ir_frame_encoder_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	output logic                                 cmd_stall,
	input  acir_pkg::cmd_t                       cmd,
	output logic                                 sym_valid,
	input  logic                                 sym_stall,
	output acir_pkg::sym_t                       sym,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [acir_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [15:0]                          cfg_data
);

	acir_pkg::cmd_t    cmd_s1;
	logic              cmd_valid_s1;
	acir_pkg::timing_t timing_q;
	acir_pkg::sym_t    out_q;
	logic              out_valid_q;
	logic              step;
	logic              res_valid;
	acir_pkg::sym_t    res;

	// Process the held transaction when the output register is free or draining
	assign step      = cmd_valid_s1 && (!out_valid_q || !sym_stall);
	assign cmd_stall = cmd_valid_s1 && !step;
	assign cfg_ready = 1'b1;
	assign sym_valid = out_valid_q;
	assign sym       = out_q;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (cmd_valid && !cmd_stall) begin
			cmd_valid_s1 <= 1'b1;
		end else if (step) begin
			cmd_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	// Timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.header_mark_us  <= 16'd6400;
			timing_q.header_space_us <= 16'd3300;
			timing_q.bit_mark_us     <= 16'd400;
			timing_q.one_space_us    <= 16'd2200;
			timing_q.zero_space_us   <= 16'd900;
			timing_q.gap_us          <= 16'd30000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				acir_pkg::REG_HEADER_MARK:  timing_q.header_mark_us  <= cfg_data;
				acir_pkg::REG_HEADER_SPACE: timing_q.header_space_us <= cfg_data;
				acir_pkg::REG_BIT_MARK:     timing_q.bit_mark_us     <= cfg_data;
				acir_pkg::REG_ONE_SPACE:    timing_q.one_space_us    <= cfg_data;
				acir_pkg::REG_ZERO_SPACE:   timing_q.zero_space_us   <= cfg_data;
				acir_pkg::REG_GAP:          timing_q.gap_us          <= cfg_data;
				default: ;
			endcase
		end
	end

	acir_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (cmd_s1),
		.timing    (timing_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= res_valid;
		end else if (!sym_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

endmodule

/* sim/acir_symbol_checker.sv */
// Symbol checker for the IR remote frame encoder testbench.
// Watches the cmd, sym and cfg channels, predicts every symbol and compares.
// Depends on acir_pkg.
module acir_symbol_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	input  logic                             cmd_stall,
	input  acir_pkg::cmd_t                   cmd,
	input  logic                             sym_valid,
	input  logic                             sym_stall,
	input  acir_pkg::sym_t                   sym,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [acir_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0]                      cfg_data,
	output int                               mismatches,
	output int                               owed
);

	// Field positions inside the frame, counted LSB first from byte 0
	localparam int MODE_LSB  = 19;
	localparam int TEMP_LSB  = 22;
	localparam int FAN_LSB   = 27;
	localparam int FLAP_LSB  = 34;
	localparam int POWER_BIT = 77;
	localparam int POST_LSB  = 80;
	localparam int CSUM_LSB  = 82;
	localparam int CSUM_BYTES = 10;

	localparam acir_pkg::timing_t TIMING_RESET = '{
		header_mark_us:  16'd6400,
		header_space_us: 16'd3300,
		bit_mark_us:     16'd400,
		one_space_us:    16'd2200,
		zero_space_us:   16'd900,
		gap_us:          16'd30000
	};

	acir_pkg::timing_t               timing;
	logic [acir_pkg::FRAME_BITS-1:0] frame_bits;
	logic [acir_pkg::SYM_IDX_W-1:0]  sym_idx;
	logic                            busy;
	acir_pkg::sym_t                  owed_syms[$];
	acir_pkg::sym_t                  want;
	acir_pkg::sym_t                  got;
	int                              bad;

	// Build the 96-bit frame for one command
	function automatic logic [acir_pkg::FRAME_BITS-1:0] pack_frame(input acir_pkg::cmd_t c);
		logic [acir_pkg::FRAME_BITS-1:0] f;
		logic [7:0]                      deg;
		logic [2:0]                      code;
		logic [7:0]                      csum;
		int                              i;
		f = '0;
		f[7:0]  = acir_pkg::PREAMBLE_A;
		f[15:8] = acir_pkg::PREAMBLE_B;
		case (c.ac_mode)
			acir_pkg::MODE_COOL: code = acir_pkg::FCODE_COOL;
			acir_pkg::MODE_DRY:  code = acir_pkg::FCODE_DRY;
			acir_pkg::MODE_HEAT: code = acir_pkg::FCODE_HEAT;
			acir_pkg::MODE_FAN:  code = acir_pkg::FCODE_FAN;
			default:             code = acir_pkg::FCODE_AUTO;
		endcase
		deg = c.temperature;
		if (deg < acir_pkg::TEMP_MIN) deg = acir_pkg::TEMP_MIN;
		else if (deg > acir_pkg::TEMP_MAX) deg = acir_pkg::TEMP_MAX;
		deg = deg - acir_pkg::TEMP_OFFSET;
		f[MODE_LSB +: 3]  = code;
		f[TEMP_LSB +: 5]  = deg[4:0];
		f[FAN_LSB +: 2]   = c.fan_speed;
		f[FLAP_LSB +: 3]  = c.swing_on ? acir_pkg::FLAP_FULL : acir_pkg::FLAP_AUTO;
		f[POWER_BIT]      = c.power_on;
		f[POST_LSB +: 2]  = acir_pkg::POST_BITS;
		csum = 8'(acir_pkg::CHECK_INIT);
		for (i = 0; i < CSUM_BYTES; i++)
			csum = csum + f[8*i +: 8];
		f[CSUM_LSB +: 8] = csum;
		return f;
	endfunction

	// Mark or space for one position of the symbol sequence
	function automatic acir_pkg::sym_t next_symbol(input logic [acir_pkg::SYM_IDX_W-1:0] idx);
		acir_pkg::sym_t s;
		int             b;
		s.level       = ~idx[0];
		s.last_symbol = 1'b0;
		if (idx == 0) begin
			s.duration = timing.header_mark_us;
		end else if (idx == 1) begin
			s.duration = timing.header_space_us;
		end else if (idx == acir_pkg::SYMBOL_COUNT - 1) begin
			s.duration    = timing.gap_us;
			s.last_symbol = 1'b1;
		end else if (s.level) begin
			s.duration = timing.bit_mark_us;
		end else begin
			b = (int'(idx) - 2) >> 1;
			s.duration = frame_bits[b] ? timing.one_space_us : timing.zero_space_us;
		end
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing     = TIMING_RESET;
			frame_bits = '0;
			sym_idx    = '0;
			busy       = 1'b0;
			bad        = 0;
			owed_syms.delete();
			mismatches <= 0;
			owed       <= 0;
		end else begin
			// Compare an accepted symbol against the oldest prediction
			if (sym_valid && !sym_stall) begin
				got = sym;
				if (owed_syms.size() == 0) begin
					$error("unexpected symbol: level %0d duration %0d last_symbol %0d",
						got.level, got.duration, got.last_symbol);
					bad++;
				end else begin
					want = owed_syms.pop_front();
					if (got.level !== want.level) begin
						$error("level: expected %0d, got %0d", want.level, got.level);
						bad++;
					end
					if (got.duration !== want.duration) begin
						$error("duration: expected %0d, got %0d",
							want.duration, got.duration);
						bad++;
					end
					if (got.last_symbol !== want.last_symbol) begin
						$error("last_symbol: expected %0d, got %0d",
							want.last_symbol, got.last_symbol);
						bad++;
					end
				end
			end

			// Track timing register writes; spare indexes are dropped
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					acir_pkg::REG_HEADER_MARK:  timing.header_mark_us  = cfg_data;
					acir_pkg::REG_HEADER_SPACE: timing.header_space_us = cfg_data;
					acir_pkg::REG_BIT_MARK:     timing.bit_mark_us     = cfg_data;
					acir_pkg::REG_ONE_SPACE:    timing.one_space_us    = cfg_data;
					acir_pkg::REG_ZERO_SPACE:   timing.zero_space_us   = cfg_data;
					acir_pkg::REG_GAP:          timing.gap_us          = cfg_data;
					default: ;
				endcase
			end

			// Advance the predicted state on each command transaction
			if (cmd_valid && !cmd_stall) begin
				if (cmd.action == acir_pkg::ACT_LOAD) begin
					frame_bits = pack_frame(cmd);
					sym_idx    = '0;
					busy       = 1'b1;
				end else if (busy) begin
					if (sym_idx >= acir_pkg::SYMBOL_COUNT)
						sym_idx = acir_pkg::SYM_IDX_W'(acir_pkg::SYMBOL_COUNT - 1);
					want = next_symbol(sym_idx);
					owed_syms.push_back(want);
					if (want.last_symbol) begin
						busy    = 1'b0;
						sym_idx = '0;
					end else begin
						sym_idx = sym_idx + 1'b1;
					end
				end
			end

			mismatches <= bad;
			owed       <= owed_syms.size();
		end
	end

endmodule

/* sim/ac_remote_ir_frame_encoder_top_tb.sv */
// Testbench top for the IR remote frame encoder: clock, reset, command and
// timing stimulus, receiver stalls and the verdict.
// Depends on acir_pkg, ac_remote_ir_frame_encoder_top and acir_symbol_checker.
module ac_remote_ir_frame_encoder_top_tb;

	localparam int ITEM_TARGET   = 1350;
	localparam int HOLD_CYCLES   = 200;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 8;

	// Register indexes past the timing set, which the block ignores
	localparam logic [acir_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [acir_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
	// Mode inputs outside the defined set, sent as auto
	localparam logic [2:0] MODE_SPARE_LO = 3'd5;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             cmd_valid = 1'b0;
	logic                             cmd_stall;
	acir_pkg::cmd_t                   cmd       = '0;
	logic                             sym_valid;
	logic                             sym_stall = 1'b0;
	acir_pkg::sym_t                   sym;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [acir_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [15:0]                      cfg_data  = '0;

	int mismatches;
	int owed;
	int sent       = 0;
	int burst_left = 0;
	int quiet      = 0;
	bit hold_pending = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	ac_remote_ir_frame_encoder_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.sym_valid (sym_valid),
		.sym_stall (sym_stall),
		.sym       (sym),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	acir_symbol_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.sym_valid  (sym_valid),
		.sym_stall  (sym_stall),
		.sym        (sym),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.owed       (owed)
	);

	// Random command; temperatures lean towards the clamp edges
	function automatic acir_pkg::cmd_t rand_cmd(input logic act);
		acir_pkg::cmd_t c;
		c.action      = act;
		c.ac_mode     = 3'($urandom_range(0, 7));
		c.temperature = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(13, 33));
		c.fan_speed   = 2'($urandom_range(0, 3));
		c.swing_on    = 1'($urandom_range(0, 1));
		c.power_on    = 1'($urandom_range(0, 1));
		return c;
	endfunction

	function automatic acir_pkg::cmd_t load_cmd(input logic [2:0] mode,
		input logic [7:0] deg, input logic [1:0] fan, input logic swing,
		input logic power);
		acir_pkg::cmd_t c;
		c.action      = acir_pkg::ACT_LOAD;
		c.ac_mode     = mode;
		c.temperature = deg;
		c.fan_speed   = fan;
		c.swing_on    = swing;
		c.power_on    = power;
		return c;
	endfunction

	function automatic logic [15:0] rand_dur();
		case ($urandom_range(0, 5))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Send one command in bursts with random gaps between them
	task automatic send(input acir_pkg::cmd_t c);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		cmd       <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		sent++;
	endtask

	// Drop valid and wait until every predicted symbol has arrived
	task automatic settle();
		cmd_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (owed != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [acir_pkg::CFG_INDEX_W-1:0] idx,
		input logic [15:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_timing(input acir_pkg::timing_t t);
		write_reg(acir_pkg::REG_HEADER_MARK,  t.header_mark_us);
		write_reg(acir_pkg::REG_HEADER_SPACE, t.header_space_us);
		write_reg(acir_pkg::REG_BIT_MARK,     t.bit_mark_us);
		write_reg(acir_pkg::REG_ONE_SPACE,    t.one_space_us);
		write_reg(acir_pkg::REG_ZERO_SPACE,   t.zero_space_us);
		write_reg(acir_pkg::REG_GAP,          t.gap_us);
		write_reg(REG_SPARE_LO,               16'($urandom_range(0, 65535)));
		write_reg(REG_SPARE_HI,               16'($urandom_range(0, 65535)));
		cfg_valid <= 1'b0;
	endtask

	// Mostly whole frames, some cut short by a reload, a few noise runs
	task automatic run_sequence();
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			send(rand_cmd(acir_pkg::ACT_LOAD));
			repeat (acir_pkg::SYMBOL_COUNT) send(rand_cmd(acir_pkg::ACT_ADVANCE));
			repeat ($urandom_range(0, 2)) send(rand_cmd(acir_pkg::ACT_ADVANCE));
		end else if (kind < 9) begin
			send(rand_cmd(acir_pkg::ACT_LOAD));
			repeat ($urandom_range(0, acir_pkg::SYMBOL_COUNT - 1))
				send(rand_cmd(acir_pkg::ACT_ADVANCE));
		end else begin
			repeat ($urandom_range(5, 20))
				send(rand_cmd(($urandom_range(0, 7) != 0) ? acir_pkg::ACT_ADVANCE
					: acir_pkg::ACT_LOAD));
		end
	endtask

	// Receiver: free stretches, random stalls, and one long hold-off
	initial begin
		int n;
		wait (arst_n);
		forever begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				sym_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				sym_stall <= 1'b0;
				repeat ($urandom_range(10, 60)) @(posedge clk);
			end else begin
				n = $urandom_range(10, 60);
				repeat (n) begin
					sym_stall <= ($urandom_range(0, 99) < 35);
					@(posedge clk);
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (sym_valid && !sym_stall)
			|| (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int                phase;
		acir_pkg::timing_t t;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle advances, every mode, clamp edges, reload mid-frame
		send(rand_cmd(acir_pkg::ACT_ADVANCE));
		send(rand_cmd(acir_pkg::ACT_ADVANCE));
		send(load_cmd(acir_pkg::MODE_AUTO, 8'd0, 2'd0, 1'b0, 1'b0));
		send(rand_cmd(acir_pkg::ACT_ADVANCE));
		send(rand_cmd(acir_pkg::ACT_ADVANCE));
		send(rand_cmd(acir_pkg::ACT_ADVANCE));
		send(load_cmd(acir_pkg::MODE_COOL, 8'd15, 2'd1, 1'b1, 1'b0));
		send(rand_cmd(acir_pkg::ACT_ADVANCE));
		send(load_cmd(acir_pkg::MODE_DRY, 8'd16, 2'd2, 1'b0, 1'b1));
		send(rand_cmd(acir_pkg::ACT_ADVANCE));
		send(load_cmd(acir_pkg::MODE_HEAT, 8'd30, 2'd3, 1'b1, 1'b1));
		send(rand_cmd(acir_pkg::ACT_ADVANCE));
		send(load_cmd(acir_pkg::MODE_FAN, 8'd31, 2'd0, 1'b0, 1'b0));
		send(rand_cmd(acir_pkg::ACT_ADVANCE));
		send(load_cmd(MODE_SPARE_LO, 8'd255, 2'd3, 1'b1, 1'b1));
		send(rand_cmd(acir_pkg::ACT_ADVANCE));
		send(load_cmd(MODE_SPARE_HI, 8'd128, 2'd1, 1'b0, 1'b1));
		send(rand_cmd(acir_pkg::ACT_ADVANCE));
		send(rand_cmd(acir_pkg::ACT_ADVANCE));
		settle();

		// Random phases: zero timings, full-scale timings, then mixed
		hold_pending = 1'b1;
		for (phase = 0; sent < ITEM_TARGET; phase++) begin
			if (phase == 0) begin
				t = '0;
			end else if (phase == 1) begin
				t = '1;
			end else begin
				t.header_mark_us  = rand_dur();
				t.header_space_us = rand_dur();
				t.bit_mark_us     = rand_dur();
				t.one_space_us    = rand_dur();
				t.zero_space_us   = rand_dur();
				t.gap_us          = rand_dur();
			end
			set_timing(t);
			repeat (2) run_sequence();
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
